@@ rtl/core/pidt_pkg.sv @@
package pidt_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_DELETE  = 2'd1,
		KIND_UPDATE  = 2'd2,
		KIND_DISPLAY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [4:0]         position;
		logic signed [31:0] data_in;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [3:0]         entry_index;
		logic signed [31:0] data_out;
		logic [4:0]         entry_count;
		logic               last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_WR,
		S_PUT,
		S_DN_RD,
		S_DN_WR,
		S_DISP_RD,
		S_DISP_OUT
	} state_t;

endpackage

@@ rtl/core/pidt_ram.sv @@
module pidt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/positional_insert_delete_table.sv @@
// A rejected edit, an empty display or a delete of the last entry strobes its result
// in the cycle after acceptance; insert first moves any entries above its position up,
// from the top, then writes the new value; delete moves entries down; update writes once.
// Every entry move is a read then a write through the single RAM port pair.
// busy drops in the same cycle as the last result is loaded; one item in flight.
// Reset (arst_n low): list count cleared, no result pending; list storage is not cleared.
module positional_insert_delete_table #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pidt_pkg::cmd_t cmd,
	output logic           rsp_valid,
	output pidt_pkg::rsp_t rsp
);

	import pidt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// common width for comparing a position against the count
	localparam int W  = (CW > 5) ? CW : 5;

	state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [31:0]   val_q, val_d;
	logic          ins_q, ins_d;

	rsp_t rsp_q, rsp_d;
	logic rsp_valid_q, emit;

	// RAM side
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	// shared index step unit: decrements while shifting up, increments otherwise
	logic [AW-1:0] idx_step;
	logic [AW-1:0] cnt_m1;
	logic [W-1:0]  pos_w, cnt_w;

	assign idx_step = (state_q == S_UP_RD || state_q == S_UP_WR)
		? idx_q - AW'(1) : idx_q + AW'(1);
	assign cnt_m1   = AW'(count_q - CW'(1));
	assign pos_w    = W'(cmd.position);
	assign cnt_w    = W'(count_q);

	pidt_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			rsp_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		val_q <= val_d;
		ins_q <= ins_d;
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		val_d     = val_q;
		ins_d     = ins_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = idx_step;
		emit      = 1'b0;
		rsp_d     = '{status: ST_OK, entry_index: '0, data_out: '0,
			entry_count: '0, last: 1'b1};

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					pos_d = AW'(cmd.position);
					val_d = cmd.data_in;
					ins_d = (cmd.kind == KIND_INSERT);
					unique case (cmd.kind)
						KIND_INSERT: begin
							if (pos_w > cnt_w) begin
								emit         = 1'b1;
								rsp_d.status = ST_BADPOS;
							end else if (count_q == CW'(DEPTH)) begin
								emit         = 1'b1;
								rsp_d.status = ST_FULL;
							end else if (pos_w == cnt_w) begin
								state_d = S_PUT;
							end else begin
								// move entries up starting from the top
								idx_d   = AW'(count_q);
								state_d = S_UP_RD;
							end
						end
						KIND_DELETE: begin
							if (pos_w >= cnt_w) begin
								emit         = 1'b1;
								rsp_d.status = ST_BADPOS;
							end else if (AW'(cmd.position) == cnt_m1) begin
								// tail entry: nothing to move
								count_d = count_q - CW'(1);
								emit    = 1'b1;
							end else begin
								idx_d   = AW'(cmd.position);
								state_d = S_DN_RD;
							end
						end
						KIND_UPDATE: begin
							if (pos_w >= cnt_w) begin
								emit         = 1'b1;
								rsp_d.status = ST_BADPOS;
							end else begin
								state_d = S_PUT;
							end
						end
						KIND_DISPLAY: begin
							if (count_q == '0) begin
								emit         = 1'b1;
								rsp_d.status = ST_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = S_DISP_RD;
							end
						end
					endcase
				end
			end
			S_UP_RD: begin
				// read entry idx-1
				state_d = S_UP_WR;
			end
			S_UP_WR: begin
				ram_we  = 1'b1;
				idx_d   = idx_step;
				state_d = (idx_step == pos_q) ? S_PUT : S_UP_RD;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
				if (ins_q) begin
					count_d = count_q + CW'(1);
				end
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_DN_RD: begin
				// read entry idx+1
				state_d = S_DN_WR;
			end
			S_DN_WR: begin
				ram_we = 1'b1;
				idx_d  = idx_step;
				if (idx_step == cnt_m1) begin
					count_d = count_q - CW'(1);
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_DN_RD;
				end
			end
			S_DISP_RD: begin
				ram_raddr = idx_q;
				state_d   = S_DISP_OUT;
			end
			S_DISP_OUT: begin
				emit              = 1'b1;
				rsp_d.entry_index = 4'(idx_q);
				rsp_d.data_out    = ram_rdata;
				rsp_d.last        = (idx_q == cnt_m1);
				idx_d             = idx_step;
				state_d           = (idx_q == cnt_m1) ? S_IDLE : S_DISP_RD;
			end
		endcase

		rsp_d.entry_count = 5'(count_d);
	end

	assign busy      = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
